[src/dual_link_health_watchdog_core_macros.svh]
// Assertion macros shared by the dual link health watchdog modules.
`ifndef DUAL_LINK_HEALTH_WATCHDOG_CORE_MACROS_SVH
`define DUAL_LINK_HEALTH_WATCHDOG_CORE_MACROS_SVH

// Implication in the same cycle, checked on the rising edge of clk outside reset.
`define DLHW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, checked on the rising edge of clk outside reset.
`define DLHW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dlhw_pkg.sv]
// Package with the opcodes, event codes, register indexes and defaults of the watchdog.
package dlhw_pkg;

    localparam int TIME_BITS_DEF    = 32;
    localparam int ATTEMPT_BITS_DEF = 8;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int INTERVAL_W  = 16;
    localparam int THRESHOLD_W = 32;
    localparam int MAX_ATT_W   = 8;
    localparam int ATT_OUT_W   = 8;
    localparam int OPCODE_W    = 3;
    localparam int EVENT_W     = 2;

    localparam logic [INTERVAL_W-1:0]  CHECK_INTERVAL_RST    = 16'd5000;
    localparam logic [THRESHOLD_W-1:0] FAILURE_THRESHOLD_RST = 32'd30000;
    localparam logic [MAX_ATT_W-1:0]   MAX_ATTEMPTS_RST      = 8'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHECK_INTERVAL    = 2'd0,
        REG_FAILURE_THRESHOLD = 2'd1,
        REG_MAX_ATTEMPTS      = 2'd2
    } cfg_index_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK     = 3'd0,
        OP_INIT     = 3'd1,
        OP_SHUTDOWN = 3'd2,
        OP_RETRY_A  = 3'd3,
        OP_RETRY_B  = 3'd4
    } op_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 2'd0,
        EV_RECOVERED = 2'd1,
        EV_LOST      = 2'd2
    } event_t;

    typedef struct packed {
        logic check;
        logic init;
        logic force_retry;
        logic connected;
    } link_cmd_t;

endpackage

[src/dlhw_link.sv]
// Per-link supervisor: last-seen time, health flag and retry attempt counter of one link.
`include "dual_link_health_watchdog_core_macros.svh"

module dlhw_link #(
    parameter int TIME_BITS    = dlhw_pkg::TIME_BITS_DEF,
    parameter int ATTEMPT_BITS = dlhw_pkg::ATTEMPT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  dlhw_pkg::link_cmd_t                 cmd,
    input  logic [TIME_BITS-1:0]                now_ms,
    input  logic [dlhw_pkg::THRESHOLD_W-1:0]    failure_threshold,
    input  logic [dlhw_pkg::MAX_ATT_W-1:0]      max_attempts,
    output logic                                healthy_next,
    output logic [ATTEMPT_BITS-1:0]             attempts_next,
    output dlhw_pkg::event_t                    link_event,
    output logic                                retry
);

    localparam int THR_CMP_W = (TIME_BITS > dlhw_pkg::THRESHOLD_W) ?
                               TIME_BITS : dlhw_pkg::THRESHOLD_W;
    localparam int ATT_CMP_W = (ATTEMPT_BITS > dlhw_pkg::MAX_ATT_W) ?
                               ATTEMPT_BITS : dlhw_pkg::MAX_ATT_W;

    logic [TIME_BITS-1:0]    last_seen_reg;
    logic [TIME_BITS-1:0]    last_seen_next;
    logic                    healthy_reg;
    logic [ATTEMPT_BITS-1:0] attempts_reg;
    logic [ATTEMPT_BITS-1:0] attempts_bumped;
    logic [TIME_BITS-1:0]    down_time;
    logic                    past_threshold;
    logic                    below_max;

    assign attempts_bumped = (attempts_reg == {ATTEMPT_BITS{1'b1}}) ?
                             attempts_reg : attempts_reg + ATTEMPT_BITS'(1);
    assign down_time       = now_ms - last_seen_reg;
    assign past_threshold  = THR_CMP_W'(down_time) > THR_CMP_W'(failure_threshold);
    assign below_max       = ATT_CMP_W'(attempts_reg) < ATT_CMP_W'(max_attempts);

    always_comb
    begin
        last_seen_next = last_seen_reg;
        healthy_next   = healthy_reg;
        attempts_next  = attempts_reg;
        link_event     = dlhw_pkg::EV_NONE;
        retry          = 1'b0;
        priority if (cmd.check)
        begin
            if (cmd.connected)
            begin
                last_seen_next = now_ms;
                attempts_next  = '0;
                if (!healthy_reg)
                begin
                    healthy_next = 1'b1;
                    link_event   = dlhw_pkg::EV_RECOVERED;
                end
            end
            else if (healthy_reg)
            begin
                healthy_next = 1'b0;
                link_event   = dlhw_pkg::EV_LOST;
            end
            else if (past_threshold && below_max)
            begin
                attempts_next = attempts_bumped;
                retry         = 1'b1;
            end
        end
        else if (cmd.init)
        begin
            healthy_next = cmd.connected;
            if (cmd.connected)
            begin
                last_seen_next = now_ms;
            end
        end
        else if (cmd.force_retry)
        begin
            attempts_next = attempts_bumped;
            retry         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seen_reg <= '0;
            healthy_reg   <= 1'b0;
            attempts_reg  <= '0;
        end
        else if (en)
        begin
            last_seen_reg <= last_seen_next;
            healthy_reg   <= healthy_next;
            attempts_reg  <= attempts_next;
        end
    end

    `DLHW_ASSERT_NEXT(a_recover_sets_healthy, en && (link_event == dlhw_pkg::EV_RECOVERED), healthy_reg, "Recovered event without the link becoming healthy.")
    `DLHW_ASSERT_NEXT(a_retry_counts, en && retry, attempts_reg != '0, "Retry issued but the attempt counter stayed at zero.")
    `DLHW_ASSERT_NEXT(a_seen_clears_count, en && cmd.check && cmd.connected, (attempts_reg == '0) && (last_seen_reg == $past(now_ms)), "Connected check did not refresh the link.")

endmodule

[src/dual_link_health_watchdog_core.sv]
// Top level of the dual link health watchdog: input register, millisecond timer and result register.
// Each item passes through the input register, then the result register, after its input transfer.
// One item per cycle when not stalled; the timer compare and both link updates are combinational.
// A stalled result register holds back the input register, which then holds back the input.
// Reset is asynchronous and active low: it stops the watchdog, clears the timer, link state
// and counters, and returns the registers to check interval 5000, threshold 30000, three attempts.
`include "dual_link_health_watchdog_core_macros.svh"

module dual_link_health_watchdog_core #(
    parameter int TIME_BITS    = dlhw_pkg::TIME_BITS_DEF,
    parameter int ATTEMPT_BITS = dlhw_pkg::ATTEMPT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dlhw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dlhw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dlhw_pkg::OPCODE_W-1:0]       opcode,
    input  logic                                link_a_connected,
    input  logic                                link_b_connected,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                link_a_healthy,
    output logic                                link_b_healthy,
    output logic                                any_healthy,
    output logic [dlhw_pkg::EVENT_W-1:0]        link_a_event,
    output logic [dlhw_pkg::EVENT_W-1:0]        link_b_event,
    output logic                                link_a_retry,
    output logic                                link_b_retry,
    output logic [dlhw_pkg::ATT_OUT_W-1:0]      link_a_attempts,
    output logic [dlhw_pkg::ATT_OUT_W-1:0]      link_b_attempts
);

    logic [dlhw_pkg::INTERVAL_W-1:0]  check_interval_reg;
    logic [dlhw_pkg::THRESHOLD_W-1:0] failure_threshold_reg;
    logic [dlhw_pkg::MAX_ATT_W-1:0]   max_attempts_reg;

    logic                             s1_valid_reg;
    logic [dlhw_pkg::OPCODE_W-1:0]    s1_op_reg;
    logic                             s1_ca_reg;
    logic                             s1_cb_reg;

    logic                             running_reg;
    logic                             running_next;
    logic [TIME_BITS-1:0]             now_reg;
    logic [TIME_BITS-1:0]             now_next;
    logic [TIME_BITS-1:0]             last_check_reg;
    logic [TIME_BITS-1:0]             since_check;

    logic                             out_valid_reg;
    logic                             a_healthy_reg;
    logic                             b_healthy_reg;
    logic                             any_healthy_reg;
    logic [dlhw_pkg::EVENT_W-1:0]     a_event_reg;
    logic [dlhw_pkg::EVENT_W-1:0]     b_event_reg;
    logic                             a_retry_reg;
    logic                             b_retry_reg;
    logic [dlhw_pkg::ATT_OUT_W-1:0]   a_attempts_reg;
    logic [dlhw_pkg::ATT_OUT_W-1:0]   b_attempts_reg;

    logic                             out_free;
    logic                             s1_fire;
    logic                             op_tick;
    logic                             op_init;
    logic                             op_shutdown;
    logic                             op_retry_a;
    logic                             op_retry_b;
    logic                             check_due;

    dlhw_pkg::link_cmd_t              a_cmd;
    dlhw_pkg::link_cmd_t              b_cmd;
    logic                             a_healthy_next;
    logic                             b_healthy_next;
    logic [ATTEMPT_BITS-1:0]          a_attempts_next;
    logic [ATTEMPT_BITS-1:0]          b_attempts_next;
    dlhw_pkg::event_t                 a_event;
    dlhw_pkg::event_t                 b_event;
    logic                             a_retry;
    logic                             b_retry;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_free;
    assign s1_fire  = s1_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_interval_reg    <= dlhw_pkg::CHECK_INTERVAL_RST;
            failure_threshold_reg <= dlhw_pkg::FAILURE_THRESHOLD_RST;
            max_attempts_reg      <= dlhw_pkg::MAX_ATTEMPTS_RST;
        end
        else if (cfg_we)
        begin
            unique case (dlhw_pkg::cfg_index_t'(cfg_index))
                dlhw_pkg::REG_CHECK_INTERVAL:
                    check_interval_reg <= cfg_data[dlhw_pkg::INTERVAL_W-1:0];
                dlhw_pkg::REG_FAILURE_THRESHOLD:
                    failure_threshold_reg <= cfg_data[dlhw_pkg::THRESHOLD_W-1:0];
                dlhw_pkg::REG_MAX_ATTEMPTS:
                    max_attempts_reg <= cfg_data[dlhw_pkg::MAX_ATT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg <= opcode;
            s1_ca_reg <= link_a_connected;
            s1_cb_reg <= link_b_connected;
        end
    end

    always_comb
    begin
        op_tick     = 1'b0;
        op_init     = 1'b0;
        op_shutdown = 1'b0;
        op_retry_a  = 1'b0;
        op_retry_b  = 1'b0;
        unique case (dlhw_pkg::op_t'(s1_op_reg))
            dlhw_pkg::OP_TICK:     op_tick     = 1'b1;
            dlhw_pkg::OP_INIT:     op_init     = !running_reg;
            dlhw_pkg::OP_SHUTDOWN: op_shutdown = 1'b1;
            dlhw_pkg::OP_RETRY_A:  op_retry_a  = 1'b1;
            dlhw_pkg::OP_RETRY_B:  op_retry_b  = 1'b1;
            default:               ;
        endcase
    end

    assign now_next     = op_tick ? now_reg + TIME_BITS'(1) : now_reg;
    assign since_check  = now_next - last_check_reg;
    assign check_due    = op_tick && running_reg &&
                          (since_check >= TIME_BITS'(check_interval_reg));
    assign running_next = op_init ? 1'b1 : (op_shutdown ? 1'b0 : running_reg);

    assign a_cmd = '{check: check_due, init: op_init, force_retry: op_retry_a,
                     connected: s1_ca_reg};
    assign b_cmd = '{check: check_due, init: op_init, force_retry: op_retry_b,
                     connected: s1_cb_reg};

    dlhw_link #(
        .TIME_BITS    (TIME_BITS),
        .ATTEMPT_BITS (ATTEMPT_BITS)
    ) u_link_a (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (s1_fire),
        .cmd               (a_cmd),
        .now_ms            (now_next),
        .failure_threshold (failure_threshold_reg),
        .max_attempts      (max_attempts_reg),
        .healthy_next      (a_healthy_next),
        .attempts_next     (a_attempts_next),
        .link_event        (a_event),
        .retry             (a_retry)
    );

    dlhw_link #(
        .TIME_BITS    (TIME_BITS),
        .ATTEMPT_BITS (ATTEMPT_BITS)
    ) u_link_b (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (s1_fire),
        .cmd               (b_cmd),
        .now_ms            (now_next),
        .failure_threshold (failure_threshold_reg),
        .max_attempts      (max_attempts_reg),
        .healthy_next      (b_healthy_next),
        .attempts_next     (b_attempts_next),
        .link_event        (b_event),
        .retry             (b_retry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            now_reg        <= '0;
            last_check_reg <= '0;
        end
        else if (s1_fire)
        begin
            running_reg <= running_next;
            now_reg     <= now_next;
            if (check_due)
            begin
                last_check_reg <= now_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            a_healthy_reg   <= a_healthy_next;
            b_healthy_reg   <= b_healthy_next;
            any_healthy_reg <= a_healthy_next | b_healthy_next;
            a_event_reg     <= a_event;
            b_event_reg     <= b_event;
            a_retry_reg     <= a_retry;
            b_retry_reg     <= b_retry;
            a_attempts_reg  <= dlhw_pkg::ATT_OUT_W'(a_attempts_next);
            b_attempts_reg  <= dlhw_pkg::ATT_OUT_W'(b_attempts_next);
        end
    end

    assign out_valid       = out_valid_reg;
    assign link_a_healthy  = a_healthy_reg;
    assign link_b_healthy  = b_healthy_reg;
    assign any_healthy     = any_healthy_reg;
    assign link_a_event    = a_event_reg;
    assign link_b_event    = b_event_reg;
    assign link_a_retry    = a_retry_reg;
    assign link_b_retry    = b_retry_reg;
    assign link_a_attempts = a_attempts_reg;
    assign link_b_attempts = b_attempts_reg;

    `DLHW_ASSERT_NEXT(a_fire_fills_result, s1_fire, out_valid_reg, "Processed item left no result in the output register.")
    `DLHW_ASSERT_NOW(a_stall_blocks_stage, out_valid_reg && !out_ready, !s1_fire, "Item processed while the result register was stalled.")
    `DLHW_ASSERT_NEXT(a_stopped_no_event, s1_fire && !running_reg, (a_event_reg == dlhw_pkg::EV_NONE) && (b_event_reg == dlhw_pkg::EV_NONE), "Link event reported while the watchdog was stopped.")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the dual link health watchdog core with a built-in predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT_DEFAULT = 26;
    localparam logic [dlhw_pkg::OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [dlhw_pkg::OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [dlhw_pkg::ATT_OUT_W-1:0] TRIES_FULL = 8'hFF;

    typedef struct packed {
        logic [dlhw_pkg::OPCODE_W-1:0] op;
        logic                          a_up;
        logic                          b_up;
    } link_item_t;

    typedef struct packed {
        logic                           a_ok;
        logic                           b_ok;
        logic                           any_ok;
        dlhw_pkg::event_t               a_ev;
        dlhw_pkg::event_t               b_ev;
        logic                           a_retry;
        logic                           b_retry;
        logic [dlhw_pkg::ATT_OUT_W-1:0] a_tries;
        logic [dlhw_pkg::ATT_OUT_W-1:0] b_tries;
    } health_report_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [dlhw_pkg::CFG_INDEX_W-1:0] cfg_index = dlhw_pkg::REG_CHECK_INTERVAL;
    logic [dlhw_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [dlhw_pkg::OPCODE_W-1:0]    opcode = dlhw_pkg::OP_TICK;
    logic                             link_a_connected = 1'b0;
    logic                             link_b_connected = 1'b0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             link_a_healthy;
    logic                             link_b_healthy;
    logic                             any_healthy;
    logic [dlhw_pkg::EVENT_W-1:0]     link_a_event;
    logic [dlhw_pkg::EVENT_W-1:0]     link_b_event;
    logic                             link_a_retry;
    logic                             link_b_retry;
    logic [dlhw_pkg::ATT_OUT_W-1:0]   link_a_attempts;
    logic [dlhw_pkg::ATT_OUT_W-1:0]   link_b_attempts;

    // Predictor copy of the registers and of the watchdog state.
    logic [dlhw_pkg::INTERVAL_W-1:0]  cfg_interval = dlhw_pkg::CHECK_INTERVAL_RST;
    logic [dlhw_pkg::THRESHOLD_W-1:0] cfg_threshold = dlhw_pkg::FAILURE_THRESHOLD_RST;
    logic [dlhw_pkg::MAX_ATT_W-1:0]   cfg_max_tries = dlhw_pkg::MAX_ATTEMPTS_RST;
    logic                             wd_running = 1'b0;
    logic [31:0]                      wd_now = '0;
    logic [31:0]                      wd_last_check = '0;
    logic [31:0]                      link_seen [2] = '{32'd0, 32'd0};
    logic                             link_ok [2] = '{1'b0, 1'b0};
    logic [dlhw_pkg::ATT_OUT_W-1:0]   link_tries [2] = '{8'd0, 8'd0};

    link_item_t     pending_items [$];
    health_report_t expected_reports [$];

    int idle_pct = IDLE_PCT_DEFAULT;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int settings_used = 0;
    int lost_seen = 0;
    int recovered_seen = 0;
    int retries_seen = 0;
    int stall_count = 0;

    dual_link_health_watchdog_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .link_a_connected (link_a_connected),
        .link_b_connected (link_b_connected),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .link_a_healthy   (link_a_healthy),
        .link_b_healthy   (link_b_healthy),
        .any_healthy      (any_healthy),
        .link_a_event     (link_a_event),
        .link_b_event     (link_b_event),
        .link_a_retry     (link_a_retry),
        .link_b_retry     (link_b_retry),
        .link_a_attempts  (link_a_attempts),
        .link_b_attempts  (link_b_attempts)
    );

    always #5 clk = ~clk;

    function automatic void bump_tries(input int idx);
        if (link_tries[idx] != TRIES_FULL)
        begin
            link_tries[idx] = link_tries[idx] + 8'd1;
        end
    endfunction

    function automatic dlhw_pkg::event_t check_one_link(input int idx, input logic up,
                                                        output logic retry);
        logic [31:0] down_for;
        retry = 1'b0;
        if (up)
        begin
            link_seen[idx] = wd_now;
            link_tries[idx] = '0;
            if (!link_ok[idx])
            begin
                link_ok[idx] = 1'b1;
                return dlhw_pkg::EV_RECOVERED;
            end
            return dlhw_pkg::EV_NONE;
        end
        if (link_ok[idx])
        begin
            link_ok[idx] = 1'b0;
            return dlhw_pkg::EV_LOST;
        end
        down_for = wd_now - link_seen[idx];
        if (down_for > cfg_threshold && link_tries[idx] < cfg_max_tries)
        begin
            bump_tries(idx);
            retry = 1'b1;
        end
        return dlhw_pkg::EV_NONE;
    endfunction

    function automatic health_report_t predict_report(input logic [dlhw_pkg::OPCODE_W-1:0] op,
                                                      input logic a_up, input logic b_up);
        health_report_t r;
        logic [31:0]    since_check;
        r = '0;
        r.a_ev = dlhw_pkg::EV_NONE;
        r.b_ev = dlhw_pkg::EV_NONE;
        case (op)
            dlhw_pkg::OP_TICK:
            begin
                wd_now = wd_now + 32'd1;
                since_check = wd_now - wd_last_check;
                if (wd_running && since_check >= {16'd0, cfg_interval})
                begin
                    wd_last_check = wd_now;
                    r.a_ev = check_one_link(0, a_up, r.a_retry);
                    r.b_ev = check_one_link(1, b_up, r.b_retry);
                end
            end
            dlhw_pkg::OP_INIT:
            begin
                if (!wd_running)
                begin
                    link_ok[0] = a_up;
                    link_ok[1] = b_up;
                    if (a_up)
                    begin
                        link_seen[0] = wd_now;
                    end
                    if (b_up)
                    begin
                        link_seen[1] = wd_now;
                    end
                    wd_running = 1'b1;
                end
            end
            dlhw_pkg::OP_SHUTDOWN:
            begin
                wd_running = 1'b0;
            end
            dlhw_pkg::OP_RETRY_A:
            begin
                bump_tries(0);
                r.a_retry = 1'b1;
            end
            dlhw_pkg::OP_RETRY_B:
            begin
                bump_tries(1);
                r.b_retry = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.a_ok = link_ok[0];
        r.b_ok = link_ok[1];
        r.any_ok = link_ok[0] | link_ok[1];
        r.a_tries = link_tries[0];
        r.b_tries = link_tries[1];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_inputs
        link_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_reports.push_back(
                    predict_report(opcode, link_a_connected, link_b_connected));
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    in_valid <= 1'b1;
                    opcode <= nxt.op;
                    link_a_connected <= nxt.a_up;
                    link_b_connected <= nxt.b_up;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        health_report_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result transfer with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("link_a_healthy", 32'(want.a_ok), 32'(link_a_healthy));
                    compare_field("link_b_healthy", 32'(want.b_ok), 32'(link_b_healthy));
                    compare_field("any_healthy", 32'(want.any_ok), 32'(any_healthy));
                    compare_field("link_a_event", 32'(want.a_ev), 32'(link_a_event));
                    compare_field("link_b_event", 32'(want.b_ev), 32'(link_b_event));
                    compare_field("link_a_retry", 32'(want.a_retry), 32'(link_a_retry));
                    compare_field("link_b_retry", 32'(want.b_retry), 32'(link_b_retry));
                    compare_field("link_a_attempts", 32'(want.a_tries),
                                  32'(link_a_attempts));
                    compare_field("link_b_attempts", 32'(want.b_tries),
                                  32'(link_b_attempts));
                    results_checked++;
                    lost_seen += (want.a_ev == dlhw_pkg::EV_LOST) +
                                 (want.b_ev == dlhw_pkg::EV_LOST);
                    recovered_seen += (want.a_ev == dlhw_pkg::EV_RECOVERED) +
                                      (want.b_ev == dlhw_pkg::EV_RECOVERED);
                    retries_seen += want.a_retry + want.b_retry;
                end
            end
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_count <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
        end
        if (stall_count >= STALL_LIMIT)
        begin
            $display("dual_link_health_watchdog_core: mismatch");
            $finish;
        end
    end

    task automatic queue_item(input logic [dlhw_pkg::OPCODE_W-1:0] op, input logic a_up,
                              input logic b_up);
        link_item_t it;
        it.op = op;
        it.a_up = a_up;
        it.b_up = b_up;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input dlhw_pkg::cfg_index_t idx,
                             input logic [dlhw_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dlhw_pkg::REG_CHECK_INTERVAL:
                cfg_interval = value[dlhw_pkg::INTERVAL_W-1:0];
            dlhw_pkg::REG_FAILURE_THRESHOLD:
                cfg_threshold = value[dlhw_pkg::THRESHOLD_W-1:0];
            dlhw_pkg::REG_MAX_ATTEMPTS:
                cfg_max_tries = value[dlhw_pkg::MAX_ATT_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_settings(input logic [dlhw_pkg::CFG_DATA_W-1:0] interval,
                                  input logic [dlhw_pkg::CFG_DATA_W-1:0] threshold,
                                  input logic [dlhw_pkg::CFG_DATA_W-1:0] max_tries);
        write_reg(dlhw_pkg::REG_CHECK_INTERVAL, interval);
        write_reg(dlhw_pkg::REG_FAILURE_THRESHOLD, threshold);
        write_reg(dlhw_pkg::REG_MAX_ATTEMPTS, max_tries);
        settings_used++;
    endtask

    // A session restarts the watchdog and then mostly ticks while the links flap in runs.
    task automatic queue_random_session(input int count);
        logic a_up;
        logic b_up;
        int   pick;
        a_up = 1'($urandom_range(1));
        b_up = 1'($urandom_range(1));
        queue_item(dlhw_pkg::OP_SHUTDOWN, 1'($urandom_range(1)), 1'($urandom_range(1)));
        queue_item(dlhw_pkg::OP_INIT, a_up, b_up);
        repeat (count)
        begin
            if ($urandom_range(9) == 0)
            begin
                a_up = ~a_up;
            end
            if ($urandom_range(9) == 0)
            begin
                b_up = ~b_up;
            end
            pick = $urandom_range(99);
            if (pick < 82)
            begin
                queue_item(dlhw_pkg::OP_TICK, a_up, b_up);
            end
            else if (pick < 87)
            begin
                queue_item(dlhw_pkg::OP_RETRY_A, a_up, b_up);
            end
            else if (pick < 92)
            begin
                queue_item(dlhw_pkg::OP_RETRY_B, a_up, b_up);
            end
            else if (pick < 95)
            begin
                queue_item(dlhw_pkg::OP_INIT, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            else if (pick < 97)
            begin
                queue_item(dlhw_pkg::OP_SHUTDOWN, a_up, b_up);
            end
            else
            begin
                queue_item(dlhw_pkg::OPCODE_W'($urandom_range(7)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        int wide;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        settings_used = 1;

        // Stopped watchdog: ticks, shutdown and spare opcodes leave the links alone; forced retries still count.
        queue_item(dlhw_pkg::OP_TICK, 1'b1, 1'b1);
        queue_item(dlhw_pkg::OP_SHUTDOWN, 1'b0, 1'b0);
        queue_item(dlhw_pkg::OP_RETRY_A, 1'b0, 1'b1);
        queue_item(dlhw_pkg::OP_RETRY_B, 1'b1, 1'b0);
        queue_item(OP_SPARE_LO, 1'b1, 1'b1);
        queue_item(OP_SPARE_HI, 1'b0, 1'b0);
        queue_item(dlhw_pkg::OP_INIT, 1'b1, 1'b0);
        queue_item(dlhw_pkg::OP_INIT, 1'b0, 1'b1);
        queue_item(dlhw_pkg::OP_TICK, 1'b0, 1'b0);
        wait_idle();

        // Zero interval: every tick of a running watchdog checks; link A is lost, link B recovers and both retry.
        apply_settings(32'd0, 32'd0, 32'd2);
        queue_item(dlhw_pkg::OP_TICK, 1'b1, 1'b0);
        queue_item(dlhw_pkg::OP_TICK, 1'b0, 1'b0);
        queue_item(dlhw_pkg::OP_TICK, 1'b0, 1'b1);
        queue_item(dlhw_pkg::OP_TICK, 1'b0, 1'b1);
        queue_item(dlhw_pkg::OP_TICK, 1'b0, 1'b1);
        queue_item(dlhw_pkg::OP_RETRY_A, 1'b0, 1'b1);
        queue_item(dlhw_pkg::OP_SHUTDOWN, 1'b0, 1'b1);
        queue_item(dlhw_pkg::OP_TICK, 1'b1, 1'b1);
        queue_item(dlhw_pkg::OP_SHUTDOWN, 1'b1, 1'b1);
        wait_idle();

        apply_settings(32'hFFFF, 32'hFFFF_FFFF, 32'hFF);
        queue_random_session(60);
        wait_idle();

        // Link A stays down long enough for the attempt counter to saturate, with no idling.
        apply_settings(32'd1, 32'd0, 32'hFF);
        idle_pct <= 0;
        queue_item(dlhw_pkg::OP_SHUTDOWN, 1'b0, 1'b1);
        queue_item(dlhw_pkg::OP_INIT, 1'b0, 1'b1);
        repeat (270) queue_item(dlhw_pkg::OP_TICK, 1'b0, 1'b1);
        repeat (3) queue_item(dlhw_pkg::OP_RETRY_A, 1'b0, 1'b1);
        repeat (3) queue_item(dlhw_pkg::OP_TICK, 1'b1, 1'b1);
        wait_idle();
        idle_pct <= IDLE_PCT_DEFAULT;

        for (int p = 0; p < 8; p++)
        begin
            wide = ($urandom_range(3) == 0);
            apply_settings($urandom_range(4),
                           wide ? $urandom : $urandom_range(15),
                           (p == 2) ? 0 : $urandom_range(5));
            queue_random_session(150);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("Checked %0d results from %0d transfers over %0d register settings.",
                 results_checked, items_sent, settings_used);
        $display("Saw %0d lost and %0d recovered events and %0d retry requests.",
                 lost_seen, recovered_seen, retries_seen);
        if (mismatches == 0)
        begin
            $display("dual_link_health_watchdog_core: match");
        end
        else
        begin
            $display("dual_link_health_watchdog_core: mismatch");
        end
        $finish;
    end

endmodule
